// ===== src/fpd_pkg.sv =====
package fpd_pkg;

  localparam int unsigned TICK_W   = 63;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned FPS_W    = 8;
  localparam int unsigned BG_W     = 6;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CIDX_W   = 2;

  // Digit-serial sweep over a 64-bit lane (tick plus one pad bit)
  localparam int unsigned LANE_W   = 64;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NDIGITS  = LANE_W / DIGIT_W;
  localparam int unsigned DCNT_W   = $clog2(NDIGITS);
  localparam int unsigned QCNT_W   = $clog2(FREQ_W);

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
  localparam logic [FPS_W-1:0]  FG_RESET   = 8'd60;
  localparam logic [BG_W-1:0]   BG_RESET   = 6'd15;
  localparam logic [FPS_W-1:0]  FG_MIN     = 8'd30;
  localparam logic [FPS_W-1:0]  FG_MAX     = 8'd240;
  localparam logic [BG_W-1:0]   BG_MIN     = 6'd5;
  localparam logic [BG_W-1:0]   BG_MAX     = 6'd60;
  localparam logic [FPS_W-1:0]  NO_TARGET  = 8'd255;

  typedef enum logic [CIDX_W-1:0] {
    REG_FREQ     = 2'd0,
    REG_FG_CAP   = 2'd1,
    REG_BG_CAP   = 2'd2,
    REG_LIMIT_BG = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

// ===== src/fpd_req_if.sv =====
interface fpd_req_if;
  logic                         valid;
  logic                         ready;
  logic [fpd_pkg::TICK_W-1:0]   now_tick;
  logic                         is_foreground;

  modport source (output valid, output now_tick, output is_foreground, input ready);
  modport sink   (input valid, input now_tick, input is_foreground, output ready);
endinterface

// ===== src/fpd_res_if.sv =====
interface fpd_res_if;
  logic                         valid;
  logic                         ready;
  logic [fpd_pkg::TICK_W-1:0]   release_tick;
  logic                         limited;
  logic                         resynced;

  modport source (output valid, output release_tick, output limited, output resynced,
                  input ready);
  modport sink   (input valid, input release_tick, input limited, input resynced,
                  output ready);
endinterface

// ===== src/frame_pacing_deadline.sv =====
// Frame pacing deadline: computes the release tick of each frame request.
// req channel: one beat per frame carries now_tick and is_foreground.
// res channel: exactly one beat per request with release_tick, limited and
// resynced. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); cap writes are clamped as they are stored, but a foreground 0 stays.
// Steps: an unlimited frame (cap 0 or frequency 0) goes from its beat straight
// to the resolve step. A limited frame is latched, runs the bit-serial
// restoring divider (frequency / target), then the 4-bit digit sweep that
// forms now - deadline, its lag compare and both candidate deadlines, and
// then resolves. A zero interval resolves right after the divider.
// Flow: one request at a time; req.ready is high only while idle, so the
// divider and the digit sweep set the rate, and no new request is taken
// until the last one has resolved.
// A finished result sits in the output register; a new request is taken while
// it waits, and that request holds in its final step until the slot frees.
// Reset: synchronous, active high; loads the default caps and frequency,
// clears the deadline (unset) and marks no target chosen yet.
module frame_pacing_deadline (
  input  logic                        clk,
  input  logic                        rst,
  fpd_req_if.sink                     req,
  fpd_res_if.source                   res,
  input  logic                        cfg_we,
  input  logic [fpd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [fpd_pkg::CFG_W-1:0]   cfg_data
);

  localparam int unsigned LW = fpd_pkg::LANE_W;
  localparam int unsigned DW = fpd_pkg::DIGIT_W;
  localparam int unsigned TW = fpd_pkg::TICK_W;
  localparam int unsigned FW = fpd_pkg::FREQ_W;
  localparam int unsigned PW = fpd_pkg::FPS_W;
  localparam int unsigned BW = fpd_pkg::BG_W;

  // Configuration registers
  logic [FW-1:0] counter_frequency;
  logic [PW-1:0] foreground_cap;
  logic [BW-1:0] background_cap;
  logic          limit_background;

  // Schedule state
  logic [TW-1:0] deadline;
  logic [PW-1:0] last_target;

  fpd_pkg::state_t state;

  // Working registers
  logic [PW-1:0]                  target;
  logic [PW-1:0]                  rem;
  logic [FW-1:0]                  quo;
  logic [fpd_pkg::QCNT_W-1:0]     qcnt;
  logic [fpd_pkg::DCNT_W-1:0]     dcnt;
  logic [LW-1:0]                  now_sr;
  logic [LW-1:0]                  dl_sr;
  logic [LW-1:0]                  int_sr;
  logic [LW-1:0]                  lim_sr;
  logic                           borrow;
  logic                           carry_now;
  logic                           carry_dl;
  logic                           diff_gt;
  logic                           diff_nz;
  logic                           dl_nz;
  logic                           pass_now;
  logic                           resync;

  // Output register
  logic          out_valid;
  logic [TW-1:0] out_tick;
  logic          out_limited;
  logic          out_resynced;

  // ---- configuration writes, clamped on the way in ----
  logic [PW-1:0] fg_wr;
  logic [BW-1:0] bg_wr;

  always_comb begin
    fg_wr = cfg_data[PW-1:0];
    if (fg_wr != '0) begin
      if (fg_wr < fpd_pkg::FG_MIN) begin
        fg_wr = fpd_pkg::FG_MIN;
      end else if (fg_wr > fpd_pkg::FG_MAX) begin
        fg_wr = fpd_pkg::FG_MAX;
      end
    end
    bg_wr = cfg_data[BW-1:0];
    if (bg_wr < fpd_pkg::BG_MIN) begin
      bg_wr = fpd_pkg::BG_MIN;
    end else if (bg_wr > fpd_pkg::BG_MAX) begin
      bg_wr = fpd_pkg::BG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_frequency <= fpd_pkg::FREQ_RESET;
      foreground_cap    <= fpd_pkg::FG_RESET;
      background_cap    <= fpd_pkg::BG_RESET;
      limit_background  <= 1'b1;
    end else if (cfg_we) begin
      case (fpd_pkg::reg_idx_t'(cfg_index))
        fpd_pkg::REG_FREQ:     counter_frequency <= cfg_data[FW-1:0];
        fpd_pkg::REG_FG_CAP:   foreground_cap    <= fg_wr;
        fpd_pkg::REG_BG_CAP:   background_cap    <= bg_wr;
        fpd_pkg::REG_LIMIT_BG: limit_background  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- request side ----
  logic          req_beat;
  logic [PW-1:0] pick;
  logic          unlimited;

  assign req.ready = (state == fpd_pkg::ST_IDLE);
  assign req_beat  = req.valid && req.ready;

  // Background cap applies only when limiting is on and the window lost focus
  assign pick = (limit_background && !req.is_foreground)
              ? {{(PW-BW){1'b0}}, background_cap} : foreground_cap;
  assign unlimited = (pick == '0) || (counter_frequency == '0);

  // ---- divider step: one quotient bit per cycle ----
  logic [PW:0]   trial;
  logic          q_bit;
  logic [PW-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[FW-1]};
    q_bit    = (trial >= {1'b0, target});
    rem_next = q_bit ? PW'(trial - {1'b0, target}) : trial[PW-1:0];
  end

  // ---- digit sweep: subtract, compare and two adds on one digit ----
  logic [DW-1:0] n_d, d_d, i_d, l_d;
  logic [DW:0]   sub_d, sum_now_d, sum_dl_d;

  always_comb begin
    n_d       = now_sr[DW-1:0];
    d_d       = dl_sr[DW-1:0];
    i_d       = int_sr[DW-1:0];
    l_d       = lim_sr[DW-1:0];
    sub_d     = {1'b0, n_d} - {1'b0, d_d} - {{DW{1'b0}}, borrow};
    sum_now_d = {1'b0, n_d} + {1'b0, i_d} + {{DW{1'b0}}, carry_now};
    sum_dl_d  = {1'b0, d_d} + {1'b0, i_d} + {{DW{1'b0}}, carry_dl};
  end

  // ---- resolve: lag past four intervals, or unset deadline ----
  logic lag;
  logic slot_free;

  assign lag       = !dl_nz || (!borrow && diff_nz && diff_gt);
  assign slot_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fpd_pkg::ST_IDLE;
      deadline    <= '0;
      last_target <= fpd_pkg::NO_TARGET;
      out_valid   <= 1'b0;
    end else begin
      // Raise the slot when a result lands, drop it once taken
      if ((state == fpd_pkg::ST_FINISH) && slot_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        fpd_pkg::ST_IDLE: begin
          if (req_beat) begin
            now_sr      <= {1'b0, req.now_tick};
            target      <= pick;
            last_target <= pick;
            rem         <= '0;
            quo         <= counter_frequency;
            qcnt        <= '0;
            if (unlimited) begin
              pass_now <= 1'b1;
              resync   <= 1'b0;
              state    <= fpd_pkg::ST_FINISH;
            end else begin
              pass_now <= 1'b0;
              // A new target restarts the schedule at now
              resync   <= (pick != last_target);
              if (pick != last_target) begin
                deadline <= req.now_tick;
              end
              state <= fpd_pkg::ST_DIVIDE;
            end
          end
        end
        fpd_pkg::ST_DIVIDE: begin
          rem  <= rem_next;
          quo  <= {quo[FW-2:0], q_bit};
          qcnt <= qcnt + 1'b1;
          if (qcnt == fpd_pkg::QCNT_W'(FW - 1)) begin
            if ({quo[FW-2:0], q_bit} == '0) begin
              // Zero interval: frame passes, any target resync stands
              pass_now <= 1'b1;
              state    <= fpd_pkg::ST_FINISH;
            end else begin
              dl_sr     <= {1'b0, deadline};
              int_sr    <= {{(LW-FW){1'b0}}, quo[FW-2:0], q_bit};
              lim_sr    <= {{(LW-FW-2){1'b0}}, quo[FW-2:0], q_bit, 2'b00};
              borrow    <= 1'b0;
              carry_now <= 1'b0;
              carry_dl  <= 1'b0;
              diff_gt   <= 1'b0;
              diff_nz   <= 1'b0;
              dl_nz     <= 1'b0;
              dcnt      <= '0;
              state     <= fpd_pkg::ST_SWEEP;
            end
          end
        end
        fpd_pkg::ST_SWEEP: begin
          // Rotate sums in at the top as operand digits leave at the bottom
          now_sr    <= {sum_now_d[DW-1:0], now_sr[LW-1:DW]};
          dl_sr     <= {sum_dl_d[DW-1:0], dl_sr[LW-1:DW]};
          int_sr    <= {{DW{1'b0}}, int_sr[LW-1:DW]};
          lim_sr    <= {{DW{1'b0}}, lim_sr[LW-1:DW]};
          borrow    <= sub_d[DW];
          carry_now <= sum_now_d[DW];
          carry_dl  <= sum_dl_d[DW];
          // Upper digits override the verdict of lower ones
          if (sub_d[DW-1:0] > l_d) begin
            diff_gt <= 1'b1;
          end else if (sub_d[DW-1:0] < l_d) begin
            diff_gt <= 1'b0;
          end
          diff_nz <= diff_nz || (sub_d[DW-1:0] != '0);
          dl_nz   <= dl_nz || (d_d != '0);
          dcnt    <= dcnt + 1'b1;
          if (dcnt == fpd_pkg::DCNT_W'(fpd_pkg::NDIGITS - 1)) begin
            state <= fpd_pkg::ST_FINISH;
          end
        end
        fpd_pkg::ST_FINISH: begin
          if (slot_free) begin
            if (pass_now) begin
              out_tick     <= now_sr[TW-1:0];
              out_limited  <= 1'b0;
              out_resynced <= resync;
            end else begin
              // Sums wrap modulo the tick width; the pad bit drops off
              out_tick     <= lag ? now_sr[TW-1:0] : dl_sr[TW-1:0];
              out_limited  <= 1'b1;
              out_resynced <= resync || lag;
              deadline     <= lag ? now_sr[TW-1:0] : dl_sr[TW-1:0];
            end
            state <= fpd_pkg::ST_IDLE;
          end
        end
        default: state <= fpd_pkg::ST_IDLE;
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.release_tick = out_tick;
  assign res.limited      = out_limited;
  assign res.resynced     = out_resynced;

endmodule
